FILE: rtl/mmcn_pkg.sv
// ----------------------------------------------------------------------------
// mmcn_pkg
// Shared constants and types of the min/max curve normaliser.
// ----------------------------------------------------------------------------
package mmcn_pkg;

	localparam int SAMPLES  = 64;
	localparam int SAMPLE_W = 24;
	localparam int ADDR_W   = $clog2(SAMPLES);
	localparam int Q_FRAC   = 16;
	localparam int QUO_W    = Q_FRAC + 1;
	localparam int DVD_W    = SAMPLE_W + QUO_W;
	localparam int STEP_W   = $clog2(QUO_W);

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [ADDR_W-1:0]          addr_t;

	// store write from the front end
	typedef struct packed {
		logic    en;
		addr_t   addr;
		sample_t data;
	} store_wr_t;

	// one finished curve, handed to the back end
	typedef struct packed {
		sample_t               min;
		logic [SAMPLE_W-1:0]   range;
	} curve_cmd_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_READ,
		B_LOAD,
		B_DIV,
		B_EMIT
	} back_state_t;

endpackage

FILE: rtl/mmcn_front.sv
// ----------------------------------------------------------------------------
// mmcn_front
// Accepts samples, writes them to the store and tracks min and max.
// ----------------------------------------------------------------------------
module mmcn_front import mmcn_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  sample_t    in_sample,
	input  logic       in_invalid,
	output store_wr_t  store_wr,
	output logic       cmd_valid,
	input  logic       cmd_ready,
	output curve_cmd_t cmd,
	input  logic       release_pulse
);

	addr_t   count_q;
	sample_t min_q;
	sample_t max_q;
	logic    hold_q;
	sample_t x;
	sample_t min_n;
	sample_t max_n;
	logic    accept;
	logic    last;

	assign in_ready = !hold_q && cmd_ready;
	assign accept   = in_valid && in_ready;
	assign x        = in_invalid ? '0 : in_sample;
	assign last     = (count_q == addr_t'(SAMPLES - 1));

	always_comb begin
		if (count_q == '0) begin
			min_n = x;
			max_n = x;
		end else begin
			min_n = (x < min_q) ? x : min_q;
			max_n = (x > max_q) ? x : max_q;
		end
	end

	assign store_wr.en   = accept;
	assign store_wr.addr = count_q;
	assign store_wr.data = x;

	assign cmd_valid = accept && last;
	assign cmd.min   = min_n;
	assign cmd.range = SAMPLE_W'(max_n - min_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			min_q   <= '0;
			max_q   <= '0;
			hold_q  <= 1'b0;
		end else begin
			if (accept) begin
				min_q   <= min_n;
				max_q   <= max_n;
				count_q <= last ? '0 : count_q + addr_t'(1);
			end
			// store is busy until the back end has read the curve out
			if (accept && last) begin
				hold_q <= 1'b1;
			end else if (release_pulse) begin
				hold_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/mmcn_cmd_queue.sv
// ----------------------------------------------------------------------------
// mmcn_cmd_queue
// Two-entry queue of finished curves between front and back end.
// ----------------------------------------------------------------------------
module mmcn_cmd_queue import mmcn_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       not_full,
	input  curve_cmd_t push_data,
	input  logic       pop,
	output logic       not_empty,
	output curve_cmd_t pop_data
);

	curve_cmd_t  slot_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  fill_q;
	logic        do_push;
	logic        do_pop;

	assign not_full  = (fill_q != 2'd2);
	assign not_empty = (fill_q != 2'd0);
	assign do_push   = push && not_full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

FILE: rtl/mmcn_back.sv
// ----------------------------------------------------------------------------
// mmcn_back
// Sample store, bit-serial divider and output register.
// ----------------------------------------------------------------------------
module mmcn_back import mmcn_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  store_wr_t   store_wr,
	input  logic        cmd_valid,
	output logic        cmd_pop,
	input  curve_cmd_t  cmd,
	output logic        release_pulse,
	output logic        out_valid,
	input  logic        out_ready,
	output sample_t     out_value,
	output logic        out_flat,
	output logic        out_last
);

	sample_t              mem [SAMPLES];
	sample_t              rd_data_q;
	logic                 rd_en;

	back_state_t          state_q;
	back_state_t          state_n;

	sample_t              min_q;
	logic [SAMPLE_W-1:0]  range_q;
	logic                 flat_q;
	addr_t                idx_q;
	logic [SAMPLE_W-1:0]  rem_q;
	logic [QUO_W-1:0]     low_q;
	logic [QUO_W-1:0]     quo_q;
	logic [STEP_W-1:0]    step_q;

	logic                 out_valid_q;
	sample_t              out_value_q;
	logic                 out_flat_q;
	logic                 out_last_q;

	logic [SAMPLE_W-1:0]  diff;
	logic [DVD_W-1:0]     dvd;
	logic [SAMPLE_W:0]    trial;
	logic                 fits;
	logic                 idx_last;
	logic                 emit;

	always_ff @(posedge clk) begin
		if (store_wr.en) begin
			mem[store_wr.addr] <= store_wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[idx_q];
		end
	end

	assign idx_last = (idx_q == addr_t'(SAMPLES - 1));
	assign diff     = SAMPLE_W'(rd_data_q - min_q);
	assign dvd      = DVD_W'({diff, {Q_FRAC{1'b0}}}) + DVD_W'(range_q >> 1);
	assign trial    = {rem_q, low_q[QUO_W-1]};
	assign fits     = (trial >= {1'b0, range_q});

	always_comb begin
		state_n       = state_q;
		cmd_pop       = 1'b0;
		rd_en         = 1'b0;
		release_pulse = 1'b0;
		emit          = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					state_n = B_READ;
				end
			end
			B_READ: begin
				rd_en   = 1'b1;
				state_n = B_LOAD;
			end
			B_LOAD: begin
				release_pulse = idx_last;
				state_n       = flat_q ? B_EMIT : B_DIV;
			end
			B_DIV: begin
				if (step_q == STEP_W'(QUO_W - 1)) begin
					state_n = B_EMIT;
				end
			end
			B_EMIT: begin
				if (!out_valid_q || out_ready) begin
					emit    = 1'b1;
					state_n = idx_last ? B_IDLE : B_READ;
				end
			end
			default: state_n = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			min_q   <= cmd.min;
			range_q <= cmd.range;
			flat_q  <= (cmd.range == '0);
			idx_q   <= '0;
		end
		if (state_q == B_LOAD) begin
			rem_q  <= dvd[DVD_W-1 -: SAMPLE_W];
			low_q  <= dvd[QUO_W-1:0];
			step_q <= '0;
		end
		if (state_q == B_DIV) begin
			rem_q  <= fits ? SAMPLE_W'(trial - {1'b0, range_q}) : trial[SAMPLE_W-1:0];
			low_q  <= {low_q[QUO_W-2:0], 1'b0};
			quo_q  <= {quo_q[QUO_W-2:0], fits};
			step_q <= step_q + STEP_W'(1);
		end
		if (emit) begin
			out_value_q <= flat_q ? rd_data_q : SAMPLE_W'(quo_q);
			out_flat_q  <= flat_q;
			out_last_q  <= idx_last;
			idx_q       <= idx_q + addr_t'(1);
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_flat  = out_flat_q;
	assign out_last  = out_last_q;

endmodule

FILE: rtl/min_max_curve_normalizer_unit.sv
// ----------------------------------------------------------------------------
// min_max_curve_normalizer_unit
// Min/max normalisation of a curve of 64 signed Q8.16 samples to Q1.16.
// ----------------------------------------------------------------------------
// Samples load at one word per cycle while input is not held off. After the
// 64th sample the whole curve is emitted in order; each normalised word passes
// through store read, dividend set-up, 17 steps of the bit-serial divider and
// output load; a flat curve skips the divider and passes its samples through.
// Input is held off from the 64th sample until the last stored sample has been
// read back for output, then the next curve may load while the final words are still being produced.
module min_max_curve_normalizer_unit import mmcn_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // [23:0] sample
	input  logic [0:0]  s_axis_tuser,  // [0] sample_invalid
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [23:0] value
	output logic [0:0]  m_axis_tuser,  // [0] is_flat
	output logic        m_axis_tlast
);

	store_wr_t  store_wr;
	logic       push;
	logic       not_full;
	curve_cmd_t push_cmd;
	logic       pop;
	logic       not_empty;
	curve_cmd_t pop_cmd;
	logic       release_pulse;
	sample_t    out_value;

	mmcn_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.in_sample     (sample_t'(s_axis_tdata)),
		.in_invalid    (s_axis_tuser[0]),
		.store_wr      (store_wr),
		.cmd_valid     (push),
		.cmd_ready     (not_full),
		.cmd           (push_cmd),
		.release_pulse (release_pulse)
	);

	mmcn_cmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.not_full  (not_full),
		.push_data (push_cmd),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_data  (pop_cmd)
	);

	mmcn_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.store_wr      (store_wr),
		.cmd_valid     (not_empty),
		.cmd_pop       (pop),
		.cmd           (pop_cmd),
		.release_pulse (release_pulse),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_value     (out_value),
		.out_flat      (m_axis_tuser[0]),
		.out_last      (m_axis_tlast)
	);

	assign m_axis_tdata = out_value;

endmodule
